// File: rtl/wsf_pkg.sv
package wsf_pkg;

    // Default field widths of the input beat
    localparam int ADC_BITS_DEF   = 24;
    localparam int COUNT_BITS_DEF = 32;

    // Shared multiplier: 33 x 33 signed, full product
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;

    // Square root: Q32.32 radicand, Q16.16 root
    localparam int SQRT_IN_W = 62;
    localparam int ROOT_W    = SQRT_IN_W / 2;
    localparam int REM_W     = ROOT_W + 3;
    localparam int ITER_W    = $clog2(ROOT_W);

    // Result beat: five fields, 159 bits, padded to whole bytes
    localparam int M_FIELDS_W = 32 + 32 + ROOT_W + 32 + 32;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_OFFSET   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_DRAG       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENCODER_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ENCODER_OFFSET = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ALPHA   = 3'd5;

    localparam logic [31:0]        RST_FORCE_GAIN     = 32'd9641600;
    localparam logic signed [31:0] RST_FORCE_OFFSET   = 32'sd292252;
    localparam logic [30:0]        RST_INV_DRAG       = 31'd4643993;
    localparam logic signed [31:0] RST_ENCODER_GAIN   = 32'sd4573;
    localparam logic signed [31:0] RST_ENCODER_OFFSET = 32'sd60093;
    localparam logic [16:0]        RST_FILTER_ALPHA   = 17'd1996;

    // Unity smoothing factor in Q1.16
    localparam logic [16:0] ALPHA_ONE = 17'd65536;

endpackage

// File: rtl/wind_speed_sensor_fusion_top.sv
// Wind speed sensor fusion. Each input beat carries a signed load-cell reading
// and a free-running encoder count; each produces exactly one result beat with
// the calibrated force, the wrapped count delta, the load-path speed
// sqrt(max(force,0) * inverse_drag), the encoder speed gain*delta + offset, and
// the mean of both speeds after their first-order low-pass filters. The force and
// speeds are signed Q16.16 with saturation. One 33x33 multiplier is shared by all five
// products under a small sequencer, and the square root runs one bit per cycle.
// The wait from accept to the result beat is set mainly by the 31-step square
// root, and the sequencer returns to idle once the result register is free.
// s_tready is high only while the sequencer is idle, and the result register
// lets a new beat be accepted while the last result waits.
// Configuration writes take effect at once and belong to idle periods.
module wind_speed_sensor_fusion_top
    import wsf_pkg::*;
#(
    parameter int ADC_BITS   = ADC_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    localparam int S_TDATA_W = ((ADC_BITS + COUNT_BITS + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // fields from bit 0: adc_sample[ADC_BITS], encoder_count[COUNT_BITS], zero pad
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,

    // fields from bit 0: force_value[32], count_delta[32], load_speed[31],
    // encoder_speed[32], fused_speed[32], zero pad
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    // Sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;  // wait for an input beat
    localparam logic [3:0] ST_MULF  = 4'd1;  // multiplier: gain * adc
    localparam logic [3:0] ST_FORCE = 4'd2;  // finish force, multiply encoder
    localparam logic [3:0] ST_ENC   = 4'd3;  // finish encoder speed, force*drag
    localparam logic [3:0] ST_LOAD  = 4'd4;  // start root, encoder filter step
    localparam logic [3:0] ST_FENC  = 4'd5;  // update encoder filter
    localparam logic [3:0] ST_SQRT  = 4'd6;  // wait for root, load filter step
    localparam logic [3:0] ST_FLOAD = 4'd7;  // update load filter
    localparam logic [3:0] ST_OUT   = 4'd8;  // load the result register

    // Configuration registers
    logic [31:0]        force_gain_reg;
    logic signed [31:0] force_offset_reg;
    logic [30:0]        inv_drag_reg;
    logic signed [31:0] encoder_gain_reg;
    logic signed [31:0] encoder_offset_reg;
    logic [16:0]        filter_alpha_reg;

    // Sequencer and persistent state
    logic [3:0]            state_reg, state_next;
    logic [COUNT_BITS-1:0] prev_count_reg;
    logic signed [31:0]    fload_reg;
    logic signed [31:0]    fenc_reg;

    // Per-item working registers
    logic signed [MUL_W-1:0] adc_reg;
    logic signed [MUL_W-1:0] delta_reg;
    logic signed [31:0]      force_reg;
    logic signed [31:0]      espeed_reg;

    // Result register
    logic                    m_tvalid_reg;
    logic [M_TDATA_W-1:0]    m_tdata_reg;

    // Shared units
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic                     sq_start;
    logic                     sq_busy;
    logic [ROOT_W-1:0]        sq_root;

    logic                    s_accept;
    logic [COUNT_BITS-1:0]   in_count;
    logic [COUNT_BITS-1:0]   raw_delta;
    logic [16:0]             alpha_sat;
    logic signed [PROD_W-1:0] force_sum;
    logic signed [PROD_W-1:0] enc_sum;
    logic signed [31:0]      force_sat;
    logic signed [31:0]      enc_sat;
    logic signed [32:0]      fused_sum;

    function automatic logic signed [PROD_W-1:0] sext32(input logic signed [31:0] x);
        return $signed({{(PROD_W-32){x[31]}}, x});
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] x);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = sext32(32'sh7fffffff);
        lo = sext32(32'sh80000000);
        if (x > hi) begin
            return 32'sh7fffffff;
        end else if (x < lo) begin
            return 32'sh80000000;
        end else begin
            return x[31:0];
        end
    endfunction

    // f + round(alpha * (x - f) / 2^16), saturated
    function automatic logic signed [31:0] lp_update(input logic signed [31:0]     f,
                                                     input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] stp;
        stp = (p + $signed(PROD_W'(32768))) >>> 16;
        return sat32(sext32(f) + stp);
    endfunction

    assign s_accept  = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_count  = s_tdata[ADC_BITS +: COUNT_BITS];
    assign raw_delta = in_count - prev_count_reg;
    assign alpha_sat = (filter_alpha_reg > ALPHA_ONE) ? ALPHA_ONE : filter_alpha_reg;
    assign sq_start  = (state_reg == ST_LOAD);

    // Finish the affine products: round-shift the force, add the biases
    assign force_sum = ((mul_p + $signed(PROD_W'(1 << 23))) >>> 24) + sext32(force_offset_reg);
    assign enc_sum   = mul_p + sext32(encoder_offset_reg);
    assign force_sat = sat32(force_sum);
    assign enc_sat   = sat32(enc_sum);
    assign fused_sum = {fload_reg[31], fload_reg} + {fenc_reg[31], fenc_reg};

    // Multiplier operand select: one product per multiplying state, zero otherwise
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MULF: begin
                mul_a = adc_reg;
                mul_b = $signed({1'b0, force_gain_reg});
            end
            ST_FORCE: begin
                mul_a = $signed({encoder_gain_reg[31], encoder_gain_reg});
                mul_b = delta_reg;
            end
            ST_ENC: begin
                // clamp negative force to zero before the drag product
                mul_a = $signed({2'b00, (force_reg[31] ? 31'd0 : force_reg[30:0])});
                mul_b = $signed({2'b00, inv_drag_reg});
            end
            ST_LOAD: begin
                mul_a = $signed({16'd0, alpha_sat});
                mul_b = $signed({espeed_reg[31], espeed_reg}) - $signed({fenc_reg[31], fenc_reg});
            end
            ST_SQRT: begin
                mul_a = $signed({16'd0, alpha_sat});
                mul_b = $signed({2'b00, sq_root}) - $signed({fload_reg[31], fload_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_accept) state_next = ST_MULF;
            ST_MULF:  state_next = ST_FORCE;
            ST_FORCE: state_next = ST_ENC;
            ST_ENC:   state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_FENC;
            ST_FENC:  state_next = ST_SQRT;
            ST_SQRT:  if (!sq_busy) state_next = ST_FLOAD;
            ST_FLOAD: state_next = ST_OUT;
            ST_OUT:   if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control, configuration and filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            m_tvalid_reg       <= 1'b0;
            prev_count_reg     <= '0;
            fload_reg          <= '0;
            fenc_reg           <= '0;
            force_gain_reg     <= RST_FORCE_GAIN;
            force_offset_reg   <= RST_FORCE_OFFSET;
            inv_drag_reg       <= RST_INV_DRAG;
            encoder_gain_reg   <= RST_ENCODER_GAIN;
            encoder_offset_reg <= RST_ENCODER_OFFSET;
            filter_alpha_reg   <= RST_FILTER_ALPHA;
        end else begin
            state_reg <= state_next;

            // Load a fresh result beat, else drop the current one once taken
            if (state_reg == ST_OUT && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            if (s_accept) begin
                prev_count_reg <= in_count;
            end
            if (state_reg == ST_FENC) begin
                fenc_reg <= lp_update(fenc_reg, mul_p);
            end
            if (state_reg == ST_FLOAD) begin
                fload_reg <= lp_update(fload_reg, mul_p);
            end

            if (cfg_wr_en) begin
                unique case (cfg_wr_index)
                    CFG_FORCE_GAIN:     force_gain_reg     <= cfg_wr_data;
                    CFG_FORCE_OFFSET:   force_offset_reg   <= $signed(cfg_wr_data);
                    CFG_INV_DRAG:       inv_drag_reg       <= cfg_wr_data[30:0];
                    CFG_ENCODER_GAIN:   encoder_gain_reg   <= $signed(cfg_wr_data);
                    CFG_ENCODER_OFFSET: encoder_offset_reg <= $signed(cfg_wr_data);
                    CFG_FILTER_ALPHA:   filter_alpha_reg   <= cfg_wr_data[16:0];
                    default: ;
                endcase
            end
        end
    end

    // Working and result payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            adc_reg   <= $signed({{(MUL_W-ADC_BITS){s_tdata[ADC_BITS-1]}},
                                  s_tdata[ADC_BITS-1:0]});
            delta_reg <= $signed({{(MUL_W-COUNT_BITS){raw_delta[COUNT_BITS-1]}}, raw_delta});
        end
        if (state_reg == ST_FORCE) begin
            force_reg <= force_sat;
        end
        if (state_reg == ST_ENC) begin
            espeed_reg <= enc_sat;
        end
        if (state_reg == ST_OUT && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= {{(M_TDATA_W-M_FIELDS_W){1'b0}},
                            fused_sum[32:1],
                            espeed_reg,
                            sq_root,
                            delta_reg[31:0],
                            force_reg};
        end
    end

    wsf_mult u_mult (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .mul_p (mul_p)
    );

    // Radicand is the force * drag product, nonnegative and below 2^62
    wsf_isqrt u_isqrt (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .sq_start    (sq_start),
        .sq_radicand (mul_p[SQRT_IN_W-1:0]),
        .sq_busy     (sq_busy),
        .sq_root     (sq_root)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: rtl/wsf_mult.sv
module wsf_mult
    import wsf_pkg::*;
(
    input  logic                     aclk,
    input  logic signed [MUL_W-1:0]  mul_a,
    input  logic signed [MUL_W-1:0]  mul_b,
    output logic signed [PROD_W-1:0] mul_p
);

    logic signed [PROD_W-1:0] prod_reg;

    // Register every product; the sequencer reads it in the next cycle
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    assign mul_p = prod_reg;

endmodule

// File: rtl/wsf_isqrt.sv
module wsf_isqrt
    import wsf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 sq_start,
    input  logic [SQRT_IN_W-1:0] sq_radicand,
    output logic                 sq_busy,
    output logic [ROOT_W-1:0]    sq_root
);

    logic                 busy_reg;
    logic [ITER_W-1:0]    iter_reg;
    logic [SQRT_IN_W-1:0] rad_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [ROOT_W-1:0]    root_reg;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             take;

    // One result bit per cycle: bring down two radicand bits, try root*4+1
    always_comb begin
        rem_sh = {rem_reg[REM_W-3:0], rad_reg[SQRT_IN_W-1 -: 2]};
        trial  = {1'b0, root_reg, 2'b01};
        take   = (rem_sh >= trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            iter_reg <= '0;
        end else if (sq_start) begin
            busy_reg <= 1'b1;
            iter_reg <= '0;
        end else if (busy_reg) begin
            iter_reg <= iter_reg + 1'b1;
            if (iter_reg == ITER_W'(ROOT_W - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (sq_start) begin
            rad_reg  <= sq_radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[SQRT_IN_W-3:0], 2'b00};
            rem_reg  <= take ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], take};
        end
    end

    assign sq_busy = busy_reg;
    assign sq_root = root_reg;

endmodule

// File: rtl/wsf_checker.sv
module wsf_checker
    import wsf_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [M_TDATA_W-1:0]  m_tdata,
    input logic                  m_tvalid,
    input logic                  m_tready
);

    // No result beat right after reset
    a_reset_clears_out: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // One item at a time: an accepted beat closes the input
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready while an item is in work");

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result beat changed while stalled");

    // Negative force gives zero load speed
    a_neg_force_zero_speed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[31]) |-> (m_tdata[94:64] == '0))
        else $error("load speed nonzero for negative force");

endmodule

bind wind_speed_sensor_fusion_top wsf_checker u_wsf_checker (.*);

// File: test/wind_speed_sensor_fusion_top_test.sv
module wind_speed_sensor_fusion_top_test;
    import wsf_pkg::*;

    localparam int S_TDATA_W = ((ADC_BITS_DEF + COUNT_BITS_DEF + 7) / 8) * 8;

    // Writes to these indexes must leave every register alone.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int RANDOM_PHASES        = 10;
    localparam int SAMPLES_PER_PHASE    = 128;
    localparam int PRESSURE_HOLD_CYCLES = 500;
    localparam int SETTLE_CYCLES        = 4;
    // Final wait after the last phase, with margin over the accept-to-result delay.
    localparam int BLOCK_LATENCY        = 48;

    // One result beat as it sits in m_tdata; first member is the top field.
    typedef struct packed {
        logic signed [31:0] fused_speed;
        logic signed [31:0] encoder_speed;
        logic [30:0]        load_speed;
        logic signed [31:0] count_delta;
        logic signed [31:0] force_value;
    } fusion_beat_t;

    // Mirrors the register file and the filter state, predicts one result beat
    // per accepted sample, and checks each result against the oldest prediction.
    class fusion_scoreboard;
        logic [31:0]        force_gain;
        logic signed [31:0] force_offset;
        logic [30:0]        inv_drag;
        logic signed [31:0] enc_gain;
        logic signed [31:0] enc_offset;
        logic [16:0]        alpha;

        logic [31:0]        prev_count;
        logic signed [31:0] filt_load;
        logic signed [31:0] filt_enc;

        fusion_beat_t pending_beats[$];
        int failures;
        int checked;

        function new();
            force_gain   = RST_FORCE_GAIN;
            force_offset = RST_FORCE_OFFSET;
            inv_drag     = RST_INV_DRAG;
            enc_gain     = RST_ENCODER_GAIN;
            enc_offset   = RST_ENCODER_OFFSET;
            alpha        = RST_FILTER_ALPHA;
            prev_count   = '0;
            filt_load    = '0;
            filt_enc     = '0;
            failures     = 0;
            checked      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_FORCE_GAIN:     force_gain   = data;
                CFG_FORCE_OFFSET:   force_offset = data;
                CFG_INV_DRAG:       inv_drag     = data[30:0];
                CFG_ENCODER_GAIN:   enc_gain     = data;
                CFG_ENCODER_OFFSET: enc_offset   = data;
                CFG_FILTER_ALPHA:   alpha        = data[16:0];
                default: ;
            endcase
        endfunction

        function logic signed [31:0] clamp32(longint v);
            if (v > 64'sd2147483647)
                return 32'h7FFF_FFFF;
            if (v < -64'sd2147483648)
                return 32'h8000_0000;
            return v[31:0];
        endfunction

        // Floor square root, settled one bit at a time from the top.
        function logic [31:0] floor_root(longint unsigned v);
            logic [31:0] root;
            longint unsigned trial;
            root = '0;
            for (int b = 31; b >= 0; b--) begin
                trial = {32'd0, root | (32'd1 << b)};
                if (trial * trial <= v)
                    root = root | (32'd1 << b);
            end
            return root;
        endfunction

        // First-order low pass with round-to-nearest step; alpha caps at one.
        function logic signed [31:0] smooth(logic signed [31:0] f, longint x);
            longint a;
            longint step;
            a = (alpha > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha);
            step = (a * (x - longint'(f)) + 64'sd32768) >>> 16;
            return clamp32(longint'(f) + step);
        endfunction

        function void note_sample(logic [ADC_BITS_DEF-1:0] adc, logic [COUNT_BITS_DEF-1:0] count);
            longint adc_v;
            longint force_l;
            longint speed_l;
            longint unsigned pos_force;
            logic signed [31:0] force_v;
            logic signed [31:0] espeed_v;
            logic [31:0] raw_delta;
            logic [31:0] root;
            fusion_beat_t want;

            adc_v   = longint'($signed(adc));
            force_l = ((adc_v * $signed({32'd0, force_gain}) + 64'sd8388608) >>> 24)
                      + longint'(force_offset);
            force_v = clamp32(force_l);
            // Negative force still reports, but the load speed is zero.
            pos_force = (force_v > 0) ? {32'd0, force_v} : 64'd0;
            root = floor_root(pos_force * {33'd0, inv_drag});

            raw_delta  = count - prev_count;
            prev_count = count;
            speed_l = longint'(enc_gain) * longint'($signed(raw_delta)) + longint'(enc_offset);
            espeed_v = clamp32(speed_l);

            filt_load = smooth(filt_load, longint'(root));
            filt_enc  = smooth(filt_enc, longint'(espeed_v));

            want.force_value   = force_v;
            want.count_delta   = raw_delta;
            want.load_speed    = root[30:0];
            want.encoder_speed = espeed_v;
            want.fused_speed   = 32'((longint'(filt_load) + longint'(filt_enc)) >>> 1);
            pending_beats.push_back(want);
        endfunction

        function bit field_differs(string name, logic [31:0] want, logic [31:0] got);
            if (want === got)
                return 1'b0;
            if (failures < 10)
                $display("  result %0d: %s expected %h got %h", checked, name, want, got);
            return 1'b1;
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] beat);
            fusion_beat_t got;
            fusion_beat_t want;
            bit bad;
            got = beat[M_FIELDS_W-1:0];
            if (pending_beats.size() == 0) begin
                if (failures < 10)
                    $display("unexpected result beat %h at %0t", beat, $realtime);
                failures++;
                return;
            end
            want = pending_beats.pop_front();
            bad = field_differs("force_value", want.force_value, got.force_value);
            bad |= field_differs("count_delta", want.count_delta, got.count_delta);
            bad |= field_differs("load_speed", {1'b0, want.load_speed}, {1'b0, got.load_speed});
            bad |= field_differs("encoder_speed", want.encoder_speed, got.encoder_speed);
            bad |= field_differs("fused_speed", want.fused_speed, got.fused_speed);
            if (bad)
                failures++;
            checked++;
        endfunction

        function int outstanding();
            return pending_beats.size();
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    fusion_scoreboard scoreboard;

    // Knobs shared by the stimulus and the output sink.
    bit src_idle_on;
    bit sink_idle_on;
    bit long_hold_req;
    logic [COUNT_BITS_DEF-1:0] last_count;
    int settings_applied;

    wind_speed_sensor_fusion_top DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tdata      (s_tdata),       // adc_sample[23:0], encoder_count[55:24]
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .m_tdata      (m_tdata),       // force_value, count_delta, load_speed,
                                       // encoder_speed, fused_speed, zero pad
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the handshake hangs; the slowest legal run is far shorter.
    initial begin
        #6000000;
        $display("run timed out with %0d results outstanding", scoreboard.outstanding());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Output sink: random stall bursts, one long hold-off on request, none when quiet.
    initial begin
        int stall_left;
        stall_left = 0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (long_hold_req) begin
                // Hold off long enough for the block to fill and stall its input.
                long_hold_req = 1'b0;
                stall_left = PRESSURE_HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 15) == 0) begin
                stall_left = $urandom_range(1, 12) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Result monitor: sample the handshake as it stood just before the edge.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            scoreboard.check_result(m_tdata);
    end

    // Write one register; the write lands on the next edge.
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(posedge aclk);
        scoreboard.write_reg(idx, data);
    endtask

    // Load a full register setting while the block is idle.
    task automatic program_block(input logic [31:0] f_gain, input logic [31:0] f_off,
                                 input logic [31:0] drag, input logic [31:0] e_gain,
                                 input logic [31:0] e_off, input logic [31:0] smoothing,
                                 input bit poke_spare);
        set_reg(CFG_FORCE_GAIN, f_gain);
        set_reg(CFG_FORCE_OFFSET, f_off);
        set_reg(CFG_INV_DRAG, drag);
        set_reg(CFG_ENCODER_GAIN, e_gain);
        set_reg(CFG_ENCODER_OFFSET, e_off);
        set_reg(CFG_FILTER_ALPHA, smoothing);
        if (poke_spare) begin
            set_reg(CFG_SPARE_LO, $urandom());
            set_reg(CFG_SPARE_HI, $urandom());
        end
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        settings_applied++;
    endtask

    // Offer one sample beat, after an optional idle burst, and hold it until taken.
    task automatic send_sample(input logic [ADC_BITS_DEF-1:0] adc,
                               input logic [COUNT_BITS_DEF-1:0] count);
        int gap;
        gap = (src_idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {count, adc};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        scoreboard.note_sample(adc, count);
        last_count = count;
    endtask

    // Drop valid and wait for every predicted result to come back.
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do
            @(posedge aclk);
        while (scoreboard.outstanding() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Mostly plausible load readings, some full-scale and some fully random.
    function automatic logic [ADC_BITS_DEF-1:0] pick_adc();
        int unsigned mode;
        mode = $urandom_range(0, 9);
        if (mode == 0) begin
            case ($urandom_range(0, 4))
                0: return 24'h80_0000;
                1: return 24'h7F_FFFF;
                2: return 24'h00_0000;
                3: return 24'hFF_FFFF;
                default: return 24'h00_0001;
            endcase
        end
        if (mode < 6)
            return ADC_BITS_DEF'($urandom_range(0, 400000) - 32'd200000);
        return ADC_BITS_DEF'($urandom());
    endfunction

    // Mostly a slowly moving counter; also stalls, half-range jumps and random values.
    function automatic logic [COUNT_BITS_DEF-1:0] pick_count();
        int unsigned mode;
        mode = $urandom_range(0, 9);
        if (mode < 6)
            return last_count + ($urandom_range(0, 400) - 32'd200);
        if (mode < 7)
            return last_count;
        if (mode < 8)
            return last_count + ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF);
        return $urandom();
    endfunction

    initial begin
        logic [31:0] f_gain, f_off, drag, e_gain, e_off, smoothing;
        int kind;

        scoreboard = new();
        last_count = '0;
        settings_applied = 0;
        src_idle_on = 1'b1;
        sink_idle_on = 1'b1;
        long_hold_req = 1'b0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset settings, counter wrap in both directions, full-scale
        // readings and a negative force.
        send_sample(24'h00_0000, 32'h0000_0000);
        send_sample(24'h7F_FFFF, 32'h0000_0001);
        send_sample(24'h80_0000, 32'h0000_0000);
        send_sample(24'hFF_FFFF, 32'hFFFF_FFFF);
        send_sample(24'h00_0001, 32'h7FFF_FFFF);
        send_sample(24'd100000, 32'hFFFF_FFFE);
        send_sample(-24'sd100000, 32'h0000_0003);
        send_sample(24'd3000000, 32'h0000_0040);
        wait_drain();

        // Everything at its top, drag and alpha written with bits above their width;
        // alpha above one makes the filters track their input.
        program_block(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_sample(24'h7F_FFFF, 32'h0000_0000);
        send_sample(24'h80_0000, 32'h8000_0000);
        send_sample(24'h00_0000, 32'h0000_0000);
        send_sample(24'h40_0000, 32'h7FFF_FFFF);
        send_sample(24'hFF_FFFF, 32'hFFFF_FFFF);
        send_sample(24'h00_0001, 32'h0000_0005);
        wait_drain();

        // Everything at its bottom: force pinned negative, filters frozen at zero alpha.
        program_block(32'h0000_0000, 32'h8000_0000, 32'h0000_0000,
                      32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 1'b0);
        send_sample(24'h7F_FFFF, 32'h1234_5678);
        send_sample(24'h80_0000, 32'h9234_5678);
        send_sample(24'h00_0000, 32'h9234_5679);
        send_sample(24'h12_3456, 32'h1234_5679);
        send_sample(24'hFF_FFFF, 32'h0000_0000);
        send_sample(24'h00_0001, 32'hFFFF_FFFF);
        wait_drain();

        // Random phases, each with its own register setting.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            kind = p % 3;
            if (p == 0) begin
                f_gain = RST_FORCE_GAIN;
                f_off = RST_FORCE_OFFSET;
                drag = RST_INV_DRAG;
                e_gain = RST_ENCODER_GAIN;
                e_off = RST_ENCODER_OFFSET;
                smoothing = RST_FILTER_ALPHA;
            end else if (kind == 1 && p != RANDOM_PHASES - 1) begin
                // Anything the port allows, spare bits included.
                f_gain = $urandom();
                f_off = $urandom();
                drag = $urandom();
                e_gain = $urandom();
                e_off = $urandom();
                smoothing = $urandom();
            end else begin
                // Plausible scales, so that results mostly stay out of saturation.
                f_gain = $urandom_range(0, 32'h0400_0000);
                f_off = $urandom_range(0, 2097152) - 32'd1048576;
                drag = $urandom_range(0, 32'h0400_0000);
                e_gain = $urandom_range(0, 131072) - 32'd65536;
                e_off = $urandom_range(0, 2097152) - 32'd1048576;
                smoothing = (kind == 2) ? $urandom_range(65537, 131071)
                                        : $urandom_range(0, 65536);
            end
            if (p == 1)
                smoothing = ALPHA_ONE;
            program_block(f_gain, f_off, drag, e_gain, e_off, smoothing, p % 2 == 1);

            // Vary which side idles; the closing phase runs at full rate.
            src_idle_on = (p % 4 != 3) && (p != RANDOM_PHASES - 1);
            sink_idle_on = (p % 4 != 2) && (p != RANDOM_PHASES - 1);
            if (p == 1)
                long_hold_req = 1'b1;

            repeat (SAMPLES_PER_PHASE)
                send_sample(pick_adc(), pick_count());
            wait_drain();
        end

        repeat (BLOCK_LATENCY) @(posedge aclk);
        $display("%0d result beats checked over %0d register settings,", scoreboard.checked,
                 settings_applied + 1);
        $display("with wrapped counters, saturated paths and a %0d-cycle output hold-off",
                 PRESSURE_HOLD_CYCLES);
        if (scoreboard.failures == 0 && scoreboard.outstanding() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d failing beats, %0d still expected", scoreboard.failures,
                     scoreboard.outstanding());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: wind_speed_sensor_fusion_top.f
rtl/wsf_pkg.sv
rtl/wsf_mult.sv
rtl/wsf_isqrt.sv
rtl/wind_speed_sensor_fusion_top.sv
rtl/wsf_checker.sv
test/wind_speed_sensor_fusion_top_test.sv
